FILE: rtl/vcpb_pkg.sv
package vcpb_pkg;

  // Q1.15 unity and field widths
  localparam int unsigned CHAN_W   = 8;
  localparam int unsigned WGT_W    = 16;
  localparam int unsigned NUM_RGB  = 3;
  localparam logic [WGT_W-1:0] Q15_ONE = 16'd32768;

  // APB register map
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned APB_ADDR_W = 3;
  localparam logic REG_IDX_BLEND = 1'b0;
  localparam logic [WGT_W-1:0] BLEND_RESET = Q15_ONE;

  // Target weight width: F*2^15 + (2^16-F)*p stays at or below 2^31
  localparam int unsigned TW_W   = 32;
  // base * weight
  localparam int unsigned TGT_W  = CHAN_W + TW_W;
  // target * blend amount
  localparam int unsigned MIX_W  = TGT_W + WGT_W;
  // current * (1 - a), Q1.15
  localparam int unsigned CURW_W = CHAN_W + WGT_W;
  // final accumulator, one bit of headroom for the rounding constant
  localparam int unsigned SUM_W  = 55;
  localparam int unsigned RES_SHIFT = 46;
  localparam int unsigned CUR_SHIFT = 31;

  // Dormant tint factors (Q0.16) and their complements 2^16 - F
  localparam logic [WGT_W-1:0] DORMANT_FACTOR [NUM_RGB] = '{16'd36045, 16'd27525, 16'd20972};
  localparam logic [WGT_W-1:0] DORMANT_COMP   [NUM_RGB] = '{16'd29491, 16'd38011, 16'd44564};

  // Per-stage load enables of the datapath
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } stage_en_t;

  // Clamp a Q1.15 weight to 1.0
  function automatic logic [WGT_W-1:0] sat_q15(input logic [WGT_W-1:0] v);
    logic [WGT_W-1:0] r;
    r = (v > Q15_ONE) ? Q15_ONE : v;
    return r;
  endfunction

endpackage

FILE: rtl/vcpb_cfg.sv
module vcpb_cfg (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [vcpb_pkg::APB_ADDR_W-1:0]       paddr,
  input  logic [vcpb_pkg::APB_DATA_W-1:0]       pwdata,
  output logic [vcpb_pkg::APB_DATA_W-1:0]       prdata,
  output logic                                  pready,
  output logic [vcpb_pkg::WGT_W-1:0]            blend_sat_o
);

  logic [vcpb_pkg::WGT_W-1:0] blend_q, blend_d;
  logic                       reg_sel;
  logic                       wr_en;

  // word index is the address above the byte offset
  assign reg_sel = (paddr[vcpb_pkg::APB_ADDR_W-1] == vcpb_pkg::REG_IDX_BLEND);
  assign wr_en   = psel && penable && pwrite && reg_sel;
  assign pready  = 1'b1;

  // register write
  always_comb begin
    blend_d = blend_q;
    if (wr_en) begin
      blend_d = pwdata[vcpb_pkg::WGT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blend_q <= vcpb_pkg::BLEND_RESET;
    end else begin
      blend_q <= blend_d;
    end
  end

  // readback
  always_comb begin
    prdata = '0;
    if (reg_sel) begin
      prdata = {{(vcpb_pkg::APB_DATA_W-vcpb_pkg::WGT_W){1'b0}}, blend_q};
    end
  end

  assign blend_sat_o = vcpb_pkg::sat_q15(blend_q);

endmodule

FILE: rtl/vcpb_ctrl.sv
module vcpb_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output vcpb_pkg::stage_en_t  en_o
);

  logic v1_q, v2_q, v3_q, v4_q;
  logic v1_d, v2_d, v3_d, v4_d;
  logic rdy1, rdy2, rdy3, rdy4;

  // a stage can load when it is empty or the one after it moves
  assign rdy4 = !v4_q || !out_stall_i;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;

  assign en_o.s1 = rdy1;
  assign en_o.s2 = rdy2;
  assign en_o.s3 = rdy3;
  assign en_o.s4 = rdy4;

  assign in_stall_o  = !rdy1;
  assign out_valid_o = v4_q;

  // valid bits follow the data
  always_comb begin
    v1_d = rdy1 ? in_valid_i : v1_q;
    v2_d = rdy2 ? v1_q : v2_q;
    v3_d = rdy3 ? v2_q : v3_q;
    v4_d = rdy4 ? v3_q : v4_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= v1_d;
      v2_q <= v2_d;
      v3_q <= v3_d;
      v4_q <= v4_d;
    end
  end

endmodule

FILE: rtl/vcpb_lane.sv
module vcpb_lane (
  input  logic                              clk_i,
  input  vcpb_pkg::stage_en_t               en_i,
  input  logic [vcpb_pkg::WGT_W-1:0]        factor_i,
  input  logic [vcpb_pkg::WGT_W-1:0]        factor_comp_i,
  input  logic [vcpb_pkg::WGT_W-1:0]        presence_i,
  input  logic [vcpb_pkg::WGT_W-1:0]        blend_i,
  input  logic [vcpb_pkg::CHAN_W-1:0]       base_i,
  input  logic [vcpb_pkg::CHAN_W-1:0]       cur_i,
  output logic [vcpb_pkg::CHAN_W-1:0]       next_o,
  output logic                              diff_o
);

  localparam int unsigned CW = vcpb_pkg::CHAN_W;

  logic [vcpb_pkg::TW_W-1:0]   tw_q1, tw_d1;
  logic [CW-1:0]               base_q1;
  logic [CW-1:0]               cur_q1, cur_q2, cur_q3;
  logic [vcpb_pkg::TGT_W-1:0]  tgt_q2, tgt_d2;
  logic [vcpb_pkg::MIX_W-1:0]  mix_q3, mix_d3;
  logic [vcpb_pkg::CURW_W-1:0] curw_q3, curw_d3;
  logic [vcpb_pkg::WGT_W-1:0]  blend_comp;
  logic [vcpb_pkg::SUM_W-1:0]  sum_d4;
  logic [CW-1:0]               next_q4, next_d4;
  logic                        diff_q4, diff_d4;

  // stage 1: target weight F*2^15 + (2^16-F)*p
  assign tw_d1 = {1'b0, factor_i, 15'd0} + 32'(32'(factor_comp_i) * 32'(presence_i));

  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      tw_q1   <= tw_d1;
      base_q1 <= base_i;
      cur_q1  <= cur_i;
    end
  end

  // stage 2: target = base * weight
  assign tgt_d2 = vcpb_pkg::TGT_W'(base_q1) * vcpb_pkg::TGT_W'(tw_q1);

  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      tgt_q2 <= tgt_d2;
      cur_q2 <= cur_q1;
    end
  end

  // stage 3: both blend products
  assign blend_comp = vcpb_pkg::Q15_ONE - blend_i;
  assign mix_d3  = vcpb_pkg::MIX_W'(tgt_q2) * vcpb_pkg::MIX_W'(blend_i);
  assign curw_d3 = vcpb_pkg::CURW_W'(cur_q2) * vcpb_pkg::CURW_W'(blend_comp);

  always_ff @(posedge clk_i) begin
    if (en_i.s3) begin
      mix_q3  <= mix_d3;
      curw_q3 <= curw_d3;
      cur_q3  <= cur_q2;
    end
  end

  // stage 4: sum, round half up, compare against current
  assign sum_d4 = (vcpb_pkg::SUM_W'(curw_q3) << vcpb_pkg::CUR_SHIFT)
                + vcpb_pkg::SUM_W'(mix_q3)
                + (vcpb_pkg::SUM_W'(1) << (vcpb_pkg::RES_SHIFT - 1));
  assign next_d4 = sum_d4[vcpb_pkg::RES_SHIFT +: CW];
  assign diff_d4 = (next_d4 != cur_q3);

  always_ff @(posedge clk_i) begin
    if (en_i.s4) begin
      next_q4 <= next_d4;
      diff_q4 <= diff_d4;
    end
  end

  assign next_o = next_q4;
  assign diff_o = diff_q4;

endmodule

FILE: rtl/vertex_color_presence_blend_core.sv
// Channel   | Direction | Handshake            | Payload
// ----------+-----------+----------------------+-------------------------------------------
// input     | in        | in_valid_i/in_stall_o| base_*_i, current_*_i, presence_i
// output    | out       | out_valid_o/out_stall_i | next_*_o, changed_o
// config    | in        | APB psel/penable     | blend_amount at byte address 0
//
// One vertex per cycle sustained while out_stall_i is low; the stages are target weight,
// base multiply, blend multiplies, and sum and round into the output register.
// The 40x16 blend multiply in stage 3 sets the critical path.
// rst_ni clears all valid bits and sets blend_amount to 1.0 (Q1.15).
// An output stall holds only the stages that are full; empty stages keep filling.
module vertex_color_presence_blend_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // input channel
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [vcpb_pkg::CHAN_W-1:0]          base_red_i,
  input  logic [vcpb_pkg::CHAN_W-1:0]          base_green_i,
  input  logic [vcpb_pkg::CHAN_W-1:0]          base_blue_i,
  input  logic [vcpb_pkg::CHAN_W-1:0]          base_alpha_i,
  input  logic [vcpb_pkg::CHAN_W-1:0]          current_red_i,
  input  logic [vcpb_pkg::CHAN_W-1:0]          current_green_i,
  input  logic [vcpb_pkg::CHAN_W-1:0]          current_blue_i,
  input  logic [vcpb_pkg::CHAN_W-1:0]          current_alpha_i,
  input  logic [vcpb_pkg::WGT_W-1:0]           presence_i,
  // output channel
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [vcpb_pkg::CHAN_W-1:0]          next_red_o,
  output logic [vcpb_pkg::CHAN_W-1:0]          next_green_o,
  output logic [vcpb_pkg::CHAN_W-1:0]          next_blue_o,
  output logic [vcpb_pkg::CHAN_W-1:0]          next_alpha_o,
  output logic                                 changed_o,
  // configuration
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [vcpb_pkg::APB_ADDR_W-1:0]      paddr,
  input  logic [vcpb_pkg::APB_DATA_W-1:0]      pwdata,
  output logic [vcpb_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                 pready
);

  localparam int unsigned CW = vcpb_pkg::CHAN_W;

  vcpb_pkg::stage_en_t        en;
  logic [vcpb_pkg::WGT_W-1:0] blend_sat;
  logic [vcpb_pkg::WGT_W-1:0] pres_sat;
  logic [CW-1:0]              base_ch [vcpb_pkg::NUM_RGB];
  logic [CW-1:0]              cur_ch  [vcpb_pkg::NUM_RGB];
  logic [CW-1:0]              next_ch [vcpb_pkg::NUM_RGB];
  logic [vcpb_pkg::NUM_RGB-1:0] diff_ch;
  logic [CW-1:0]              alpha_q1, alpha_q2, alpha_q3, alpha_q4;
  logic                       adiff_q1, adiff_q2, adiff_q3, adiff_q4;

  // configuration register
  vcpb_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .blend_sat_o (blend_sat)
  );

  // pipeline valid/enable chain
  vcpb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .en_o        (en)
  );

  assign pres_sat = vcpb_pkg::sat_q15(presence_i);

  assign base_ch[0] = base_red_i;
  assign base_ch[1] = base_green_i;
  assign base_ch[2] = base_blue_i;
  assign cur_ch[0]  = current_red_i;
  assign cur_ch[1]  = current_green_i;
  assign cur_ch[2]  = current_blue_i;

  // one lane per color channel
  for (genvar g = 0; g < vcpb_pkg::NUM_RGB; g++) begin : g_lane
    vcpb_lane u_lane (
      .clk_i         (clk_i),
      .en_i          (en),
      .factor_i      (vcpb_pkg::DORMANT_FACTOR[g]),
      .factor_comp_i (vcpb_pkg::DORMANT_COMP[g]),
      .presence_i    (pres_sat),
      .blend_i       (blend_sat),
      .base_i        (base_ch[g]),
      .cur_i         (cur_ch[g]),
      .next_o        (next_ch[g]),
      .diff_o        (diff_ch[g])
    );
  end

  // alpha passes through, its change bit rides along
  always_ff @(posedge clk_i) begin
    if (en.s1) begin
      alpha_q1 <= base_alpha_i;
      adiff_q1 <= (base_alpha_i != current_alpha_i);
    end
    if (en.s2) begin
      alpha_q2 <= alpha_q1;
      adiff_q2 <= adiff_q1;
    end
    if (en.s3) begin
      alpha_q3 <= alpha_q2;
      adiff_q3 <= adiff_q2;
    end
    if (en.s4) begin
      alpha_q4 <= alpha_q3;
      adiff_q4 <= adiff_q3;
    end
  end

  assign next_red_o   = next_ch[0];
  assign next_green_o = next_ch[1];
  assign next_blue_o  = next_ch[2];
  assign next_alpha_o = alpha_q4;
  assign changed_o    = (|diff_ch) | adiff_q4;

endmodule

FILE: rtl/vcpb_checker.sv
module vcpb_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_stall_o,
  input logic                             out_valid_o,
  input logic                             out_stall_i,
  input logic [vcpb_pkg::CHAN_W-1:0]      next_red_o,
  input logic [vcpb_pkg::CHAN_W-1:0]      next_alpha_o,
  input logic                             changed_o,
  input logic                             psel,
  input logic                             penable,
  input logic                             pwrite,
  input logic [vcpb_pkg::APB_ADDR_W-1:0]  paddr,
  input logic [vcpb_pkg::APB_DATA_W-1:0]  pwdata,
  input logic [vcpb_pkg::APB_DATA_W-1:0]  prdata
);

  // a result waiting on a stall stays offered
  a_out_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output valid dropped under stall");

  // a stalled result does not change
  a_out_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      $stable(next_red_o) && $stable(next_alpha_o) && $stable(changed_o))
    else $error("output payload changed under stall");

  // with the output register empty the pipeline must take input
  a_no_stall_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty output stage");

  // a write to the blend register reads back on the next cycle
  a_cfg_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite && (paddr[vcpb_pkg::APB_ADDR_W-1] == vcpb_pkg::REG_IDX_BLEND)
    |=> (paddr[vcpb_pkg::APB_ADDR_W-1] != vcpb_pkg::REG_IDX_BLEND) ||
        (prdata[vcpb_pkg::WGT_W-1:0] == $past(pwdata[vcpb_pkg::WGT_W-1:0])))
    else $error("blend register readback mismatch");

endmodule

bind vertex_color_presence_blend_core vcpb_checker u_vcpb_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .next_red_o   (next_red_o),
  .next_alpha_o (next_alpha_o),
  .changed_o    (changed_o),
  .psel         (psel),
  .penable      (penable),
  .pwrite       (pwrite),
  .paddr        (paddr),
  .pwdata       (pwdata),
  .prdata       (prdata)
);
